@@ rtl/oli_pkg.sv @@
// ----------------------------------------------------------------------------
// oli_pkg: shared types and constants for the ordered list block
// Operation codes, status codes, controller states and the per-cell operation.
// ----------------------------------------------------------------------------
package oli_pkg;

  // Default number of cells in the chain.
  localparam int DefaultDepth = 16;

  // Width of one stored value.
  localparam int ValW = 32;

  // Operation codes carried by the func field.
  typedef enum logic [2:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_POS   = 3'd1,
    FN_INS_END   = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_POS   = 3'd4,
    FN_DEL_END   = 3'd5,
    FN_DISPLAY   = 3'd6
  } func_t;

  // Status codes returned with each result word.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_POS   = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DISP = 1'b1
  } state_t;

  // What a cell loads at the next clock edge.
  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_LOAD       = 3'd1,
    CELL_FROM_LEFT  = 3'd2,
    CELL_FROM_RIGHT = 3'd3,
    CELL_FROM_HEAD  = 3'd4
  } cell_op_t;

endpackage

@@ rtl/ordered_list_insert_delete.sv @@
// Insert and delete: one word out, registered at acceptance and shown in the next cycle.
// Throughput: one insert or delete per cycle while the output is taken, set by the parallel cell shift.
// Display of N entries: N words, one per cycle while the output is taken, from
// the display state, by rotating the occupied cells through the head.
// Reset clears the entry count, the controller and the output valid; cell
// contents are left as they are.
// ----------------------------------------------------------------------------
// ordered_list_insert_delete: bounded ordered list in a chain of cells
// Inserts, deletes and displays signed 32-bit values kept in list order.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete #(
  parameter int DEPTH = oli_pkg::DefaultDepth
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      func,
  input  logic [4:0]                      position,
  input  logic signed [oli_pkg::ValW-1:0] value_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [oli_pkg::ValW-1:0] value_out,
  output logic [1:0]                      status,
  output logic                            last
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);
  localparam int PosW = ((CntW > 5) ? CntW : 5) + 1;

  // Registers.
  oli_pkg::state_t                 state;
  oli_pkg::state_t                 state_next;
  logic [CntW-1:0]                 entry_count;
  logic [CntW-1:0]                 entry_count_next;
  logic [CntW-1:0]                 disp_left;
  logic [CntW-1:0]                 disp_left_next;

  // Cell chain.
  logic signed [oli_pkg::ValW-1:0] cell_val [DEPTH];
  oli_pkg::cell_op_t               cell_op  [DEPTH];

  // Decode and control.
  oli_pkg::func_t                  fn;
  logic                            accept;
  logic                            slot_free;
  logic                            full;
  logic                            empty;
  logic [PosW-1:0]                 pos_w;
  logic [PosW-1:0]                 cnt_w;
  logic                            ins_pos_ok;
  logic                            del_pos_ok;
  logic [IdxW-1:0]                 op_idx;
  logic                            ins_do;
  logic                            del_do;
  logic                            rot_do;
  logic                            load_out;
  logic signed [oli_pkg::ValW-1:0] res_val;
  oli_pkg::status_t                res_stat;
  logic                            res_last;

  assign fn        = oli_pkg::func_t'(func);
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == oli_pkg::S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign full      = (entry_count == CntW'(DEPTH));
  assign empty     = (entry_count == '0);

  // Position range checks on a common width.
  assign pos_w      = PosW'(position);
  assign cnt_w      = PosW'(entry_count);
  assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + PosW'(1));
  assign del_pos_ok = (pos_w != '0) && (pos_w <= cnt_w);

  // Cell index that the operation works on.
  always_comb begin
    unique case (fn)
      oli_pkg::FN_INS_POS,
      oli_pkg::FN_DEL_POS: op_idx = IdxW'(pos_w - PosW'(1));
      oli_pkg::FN_INS_END: op_idx = IdxW'(entry_count);
      oli_pkg::FN_DEL_END: op_idx = IdxW'(entry_count - CntW'(1));
      default:             op_idx = '0;
    endcase
  end

  // Controller: next state, count and result word.
  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    disp_left_next   = disp_left;
    load_out         = 1'b0;
    res_val          = '0;
    res_stat         = oli_pkg::STAT_OK;
    res_last         = 1'b1;
    ins_do           = 1'b0;
    del_do           = 1'b0;
    rot_do           = 1'b0;
    unique case (state)
      oli_pkg::S_IDLE: begin
        if (accept) begin
          unique case (fn)
            oli_pkg::FN_INS_FRONT,
            oli_pkg::FN_INS_POS,
            oli_pkg::FN_INS_END: begin
              load_out = 1'b1;
              if (full) begin
                res_stat = oli_pkg::STAT_FULL;
              end else if (fn == oli_pkg::FN_INS_POS && !ins_pos_ok) begin
                res_stat = oli_pkg::STAT_POS;
              end else begin
                ins_do           = 1'b1;
                entry_count_next = entry_count + CntW'(1);
              end
            end
            oli_pkg::FN_DEL_FRONT,
            oli_pkg::FN_DEL_POS,
            oli_pkg::FN_DEL_END: begin
              load_out = 1'b1;
              if (empty) begin
                res_stat = oli_pkg::STAT_EMPTY;
              end else if (fn == oli_pkg::FN_DEL_POS && !del_pos_ok) begin
                res_stat = oli_pkg::STAT_POS;
              end else begin
                del_do           = 1'b1;
                res_val          = cell_val[op_idx];
                entry_count_next = entry_count - CntW'(1);
              end
            end
            oli_pkg::FN_DISPLAY: begin
              if (empty) begin
                load_out = 1'b1;
                res_stat = oli_pkg::STAT_EMPTY;
              end else begin
                state_next     = oli_pkg::S_DISP;
                disp_left_next = entry_count;
              end
            end
            default: begin
            end
          endcase
        end
      end
      oli_pkg::S_DISP: begin
        if (slot_free) begin
          load_out       = 1'b1;
          res_val        = cell_val[0];
          res_last       = (disp_left == CntW'(1));
          rot_do         = 1'b1;
          disp_left_next = disp_left - CntW'(1);
          if (disp_left == CntW'(1)) begin
            state_next = oli_pkg::S_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Per-cell orders: shift right on insert, left on delete, rotate on display.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = oli_pkg::CELL_HOLD;
      if (ins_do) begin
        if (IdxW'(i) == op_idx) begin
          cell_op[i] = oli_pkg::CELL_LOAD;
        end else if (IdxW'(i) > op_idx) begin
          cell_op[i] = oli_pkg::CELL_FROM_LEFT;
        end
      end else if (del_do) begin
        if (IdxW'(i) >= op_idx && i < DEPTH - 1) begin
          cell_op[i] = oli_pkg::CELL_FROM_RIGHT;
        end
      end else if (rot_do) begin
        if (CntW'(i + 1) < entry_count) begin
          cell_op[i] = oli_pkg::CELL_FROM_RIGHT;
        end else if (CntW'(i + 1) == entry_count) begin
          cell_op[i] = oli_pkg::CELL_FROM_HEAD;
        end
      end
    end
  end

  // The chain of cells, each wired to its neighbours and the head.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [oli_pkg::ValW-1:0] left_val;
    logic signed [oli_pkg::ValW-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = cell_val[g];
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_val = cell_val[g];
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end

    oli_cell u_cell (
      .clk       (clk),
      .op        (cell_op[g]),
      .load_val  (value_in),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (cell_val[0]),
      .val       (cell_val[g])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= oli_pkg::S_IDLE;
      entry_count <= '0;
      disp_left   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      disp_left   <= disp_left_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      value_out <= res_val;
      status    <= res_stat;
      last      <= res_last;
    end
  end

endmodule

@@ rtl/oli_cell.sv @@
// ----------------------------------------------------------------------------
// oli_cell: one storage cell of the list chain
// Holds one value and takes a new one from the input word, a neighbour or the
// head of the chain, as the controller orders.
// ----------------------------------------------------------------------------
module oli_cell (
  input  logic                              clk,
  input  oli_pkg::cell_op_t                 op,
  input  logic signed [oli_pkg::ValW-1:0]   load_val,
  input  logic signed [oli_pkg::ValW-1:0]   left_val,
  input  logic signed [oli_pkg::ValW-1:0]   right_val,
  input  logic signed [oli_pkg::ValW-1:0]   head_val,
  output logic signed [oli_pkg::ValW-1:0]   val
);

  logic signed [oli_pkg::ValW-1:0] val_next;

  // Select the source for the stored value.
  always_comb begin
    unique case (op)
      oli_pkg::CELL_LOAD:       val_next = load_val;
      oli_pkg::CELL_FROM_LEFT:  val_next = left_val;
      oli_pkg::CELL_FROM_RIGHT: val_next = right_val;
      oli_pkg::CELL_FROM_HEAD:  val_next = head_val;
      default:                  val_next = val;
    endcase
  end

  // The stored value is payload and needs no reset.
  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ordered_list_insert_delete
// A directed table covers the empty, full and out-of-range cases, inserts and
// deletes at both ends and at positions, and display. Random operations follow.
// Every word is checked against a shadow copy of the list kept by the bench.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = oli_pkg::DefaultDepth;
  localparam int ValW = oli_pkg::ValW;
  localparam int RandomItems = 84;
  localparam int SettleCycles = 40;

  // The func field can carry a code that no operation uses.
  localparam logic [2:0] FN_UNUSED = 3'd7;

  // One result word as the bench expects it.
  typedef struct packed {
    logic signed [ValW-1:0] value;
    oli_pkg::status_t       status;
    logic                   last;
  } list_word_t;

  // One row of the directed table. A typed row carries its single expected
  // word; the others are worked out by the shadow list.
  typedef struct {
    logic [2:0]             op;
    logic [4:0]             pos;
    logic signed [ValW-1:0] val;
    int                     reps;
    bit                     rand_val;
    bit                     typed;
    logic signed [ValW-1:0] exp_value;
    oli_pkg::status_t       exp_status;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [2:0]             func = 3'd0;
  logic [4:0]             position = 5'd0;
  logic signed [ValW-1:0] value_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [ValW-1:0] value_out;
  logic [1:0]             status;
  logic                   last;

  // Shadow of the word on the input, driven together with the payload.
  bit         cur_typed = 1'b0;
  list_word_t cur_word = '0;

  // Shadow list and the words still owed by the block.
  logic signed [ValW-1:0] shadow_list [DEPTH];
  int                     shadow_count = 0;
  list_word_t             due_words [$];
  int                     fails = 0;
  int                     burst_left = 0;
  stim_row_t              directed_rows [$];

  ordered_list_insert_delete #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .position (position),
    .value_in (value_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value_out(value_out),
    .status   (status),
    .last     (last)
  );

  always #4 clk = ~clk;

  // Applies one accepted operation to the shadow list and queues the words
  // it should produce. A typed row queues its written-in word instead.
  task automatic predict_op(input logic [2:0] op, input logic [4:0] pos,
                            input logic signed [ValW-1:0] val, input bit typed,
                            input list_word_t typed_word);
    list_word_t words [$];
    list_word_t w;
    int         idx;
    w.value = '0;
    w.status = oli_pkg::STAT_OK;
    w.last = 1'b1;
    idx = 0;
    case (op)
      oli_pkg::FN_INS_FRONT, oli_pkg::FN_INS_POS, oli_pkg::FN_INS_END: begin
        // A full list is reported before a bad position.
        if (shadow_count >= DEPTH) begin
          w.status = oli_pkg::STAT_FULL;
        end else if (op == oli_pkg::FN_INS_POS &&
                     (pos < 1 || pos > shadow_count + 1)) begin
          w.status = oli_pkg::STAT_POS;
        end else begin
          if (op == oli_pkg::FN_INS_POS) idx = pos - 1;
          else if (op == oli_pkg::FN_INS_END) idx = shadow_count;
          for (int i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[idx] = val;
          shadow_count++;
        end
        words.push_back(w);
      end
      oli_pkg::FN_DEL_FRONT, oli_pkg::FN_DEL_POS, oli_pkg::FN_DEL_END: begin
        // An empty list is reported before a bad position.
        if (shadow_count == 0) begin
          w.status = oli_pkg::STAT_EMPTY;
        end else if (op == oli_pkg::FN_DEL_POS &&
                     (pos < 1 || pos > shadow_count)) begin
          w.status = oli_pkg::STAT_POS;
        end else begin
          if (op == oli_pkg::FN_DEL_POS) idx = pos - 1;
          else if (op == oli_pkg::FN_DEL_END) idx = shadow_count - 1;
          w.value = shadow_list[idx];
          for (int i = idx; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
        words.push_back(w);
      end
      oli_pkg::FN_DISPLAY: begin
        if (shadow_count == 0) begin
          w.status = oli_pkg::STAT_EMPTY;
          words.push_back(w);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            w.value = shadow_list[i];
            w.last = (i == shadow_count - 1);
            words.push_back(w);
          end
        end
      end
      default: ;
    endcase
    if (typed) begin
      if (words.size() != 0) due_words.push_back(typed_word);
    end else begin
      foreach (words[k]) due_words.push_back(words[k]);
    end
  endtask

  // Predicts on every accepted operation and checks every accepted word.
  always @(posedge clk) begin : word_monitor
    list_word_t want;
    if (!rst) begin
      if (in_valid && in_ready) predict_op(func, position, value_in, cur_typed, cur_word);
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          $error("word with none expected: value_out %0d status %0d last %0b",
                 value_out, status, last);
          fails++;
        end else begin
          want = due_words.pop_front();
          if (value_out !== want.value) begin
            $error("value_out: expected %0d, got %0d", want.value, value_out);
            fails++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fails++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            fails++;
          end
        end
      end
    end
  end

  // Receiver: phases of steady acceptance, a rotating stall pattern and
  // sparse random acceptance.
  always @(posedge clk) begin : receiver
    static int          phase_left = 0;
    static int          mode = 0;
    static logic [15:0] ready_pattern = 16'h0001;
    if (phase_left == 0) begin
      phase_left = $urandom_range(20, 80);
      mode = $urandom_range(0, 2);
      ready_pattern = 16'($urandom) | 16'h0001;
    end
    phase_left--;
    ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
    case (mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ready_pattern[0];
      default: out_ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // Presents one word and holds it until accepted. The sender runs in bursts
  // with idle gaps between them.
  task automatic send_word(input logic [2:0] op, input logic [4:0] pos,
                           input logic signed [ValW-1:0] val, input bit typed,
                           input list_word_t typed_word);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    burst_left--;
    in_valid  <= 1'b1;
    func      <= op;
    position  <= pos;
    value_in  <= val;
    cur_typed <= typed;
    cur_word  <= typed_word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops sending until every owed word has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic stim_row_t mk_row(input logic [2:0] op, input logic [4:0] pos,
                                       input logic signed [ValW-1:0] val,
                                       input int reps, input int rand_val,
                                       input int typed,
                                       input logic signed [ValW-1:0] exp_value,
                                       input oli_pkg::status_t exp_status);
    stim_row_t row;
    row.op = op;
    row.pos = pos;
    row.val = val;
    row.reps = reps;
    row.rand_val = (rand_val != 0);
    row.typed = (typed != 0);
    row.exp_value = exp_value;
    row.exp_status = exp_status;
    return row;
  endfunction

  initial begin : stimulus
    list_word_t             typed_word;
    logic [2:0]             op;
    logic [4:0]             pos;
    logic signed [ValW-1:0] val;
    int                     sent;
    bit                     paused;
    bit                     grow;
    int                     pick;

    // Empty list: every delete and display reports empty, bad insert
    // positions are refused.
    directed_rows.push_back(mk_row(oli_pkg::FN_DISPLAY, 5'd0, 0, 1, 0, 1,
                                   0, oli_pkg::STAT_EMPTY));
    directed_rows.push_back(mk_row(oli_pkg::FN_DEL_FRONT, 5'd0, 0, 1, 0, 1,
                                   0, oli_pkg::STAT_EMPTY));
    directed_rows.push_back(mk_row(oli_pkg::FN_DEL_END, 5'd0, 0, 1, 0, 1,
                                   0, oli_pkg::STAT_EMPTY));
    directed_rows.push_back(mk_row(oli_pkg::FN_DEL_POS, 5'd1, 0, 1, 0, 1,
                                   0, oli_pkg::STAT_EMPTY));
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_POS, 5'd0, 5, 1, 0, 1,
                                   0, oli_pkg::STAT_POS));
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_POS, 5'd2, 5, 1, 0, 1,
                                   0, oli_pkg::STAT_POS));
    // Insert at the end of an empty list, then delete the end of a
    // one-element list.
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_END, 5'd0, 32'h1234_5678, 1, 0, 1,
                                   0, oli_pkg::STAT_OK));
    directed_rows.push_back(mk_row(oli_pkg::FN_DEL_END, 5'd0, 0, 1, 0, 1,
                                   32'h1234_5678, oli_pkg::STAT_OK));
    // Build [-1, min, max, 0] using each insert flavour, position 1 included.
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_POS, 5'd1, 32'h8000_0000, 1, 0, 1,
                                   0, oli_pkg::STAT_OK));
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_FRONT, 5'd0, -1, 1, 0, 1,
                                   0, oli_pkg::STAT_OK));
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_END, 5'd0, 32'h7FFF_FFFF, 1, 0, 1,
                                   0, oli_pkg::STAT_OK));
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_POS, 5'd4, 0, 1, 0, 1,
                                   0, oli_pkg::STAT_OK));
    directed_rows.push_back(mk_row(oli_pkg::FN_DISPLAY, 5'd0, 0, 1, 0, 0,
                                   0, oli_pkg::STAT_OK));
    // Bad delete positions, then delete at position 1 and from the front.
    directed_rows.push_back(mk_row(oli_pkg::FN_DEL_POS, 5'd5, 0, 1, 0, 1,
                                   0, oli_pkg::STAT_POS));
    directed_rows.push_back(mk_row(oli_pkg::FN_DEL_POS, 5'd0, 0, 1, 0, 1,
                                   0, oli_pkg::STAT_POS));
    directed_rows.push_back(mk_row(oli_pkg::FN_DEL_POS, 5'd1, 0, 1, 0, 1,
                                   -1, oli_pkg::STAT_OK));
    directed_rows.push_back(mk_row(oli_pkg::FN_DEL_FRONT, 5'd0, 0, 1, 0, 1,
                                   32'h8000_0000, oli_pkg::STAT_OK));
    // The unused code must be ignored.
    directed_rows.push_back(mk_row(FN_UNUSED, 5'd31, -1, 1, 0, 0,
                                   0, oli_pkg::STAT_OK));
    // Fill to one short of full, then take the last slot by position.
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_END, 5'd0, 0, 13, 1, 0,
                                   0, oli_pkg::STAT_OK));
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_POS, 5'd16, 0, 1, 1, 1,
                                   0, oli_pkg::STAT_OK));
    // Full list: full is reported before a bad position.
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_FRONT, 5'd0, 1, 1, 0, 1,
                                   0, oli_pkg::STAT_FULL));
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_POS, 5'd31, 1, 1, 0, 1,
                                   0, oli_pkg::STAT_FULL));
    directed_rows.push_back(mk_row(oli_pkg::FN_INS_END, 5'd0, 1, 1, 0, 1,
                                   0, oli_pkg::STAT_FULL));
    directed_rows.push_back(mk_row(oli_pkg::FN_DISPLAY, 5'd0, 0, 1, 0, 0,
                                   0, oli_pkg::STAT_OK));
    directed_rows.push_back(mk_row(oli_pkg::FN_DEL_POS, 5'd16, 0, 1, 0, 0,
                                   0, oli_pkg::STAT_OK));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        typed_word.value = directed_rows[r].exp_value;
        typed_word.status = directed_rows[r].exp_status;
        typed_word.last = 1'b1;
        val = directed_rows[r].rand_val ? ValW'($urandom) : directed_rows[r].val;
        send_word(directed_rows[r].op, directed_rows[r].pos, val,
                  directed_rows[r].typed, typed_word);
      end
    end

    // Random part: phases that favour inserts alternate with phases that
    // favour deletes, so the list grows and shrinks in turn.
    sent = 0;
    paused = 1'b0;
    while (sent < RandomItems) begin
      if (sent == RandomItems / 2 && !paused) begin
        wait_for_results();
        paused = 1'b1;
      end
      grow = ((sent / 20) % 2 == 0);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op = FN_UNUSED;
      end else if (pick < 12) begin
        op = oli_pkg::FN_DISPLAY;
      end else if (pick < (grow ? 72 : 40)) begin
        case ($urandom_range(0, 2))
          0:       op = oli_pkg::FN_INS_FRONT;
          1:       op = oli_pkg::FN_INS_POS;
          default: op = oli_pkg::FN_INS_END;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       op = oli_pkg::FN_DEL_FRONT;
          1:       op = oli_pkg::FN_DEL_POS;
          default: op = oli_pkg::FN_DEL_END;
        endcase
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) pos = 5'($urandom_range(1, 9));
      else if (pick < 9) pos = 5'($urandom_range(1, 17));
      else pos = 5'($urandom_range(0, 31));
      case ($urandom_range(0, 7))
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7FFF_FFFF;
        2:       val = -1;
        3:       val = 0;
        default: val = ValW'($urandom);
      endcase
      send_word(op, pos, val, 1'b0, '0);
      if (op != FN_UNUSED) sent++;
    end

    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
    if (due_words.size() != 0) begin
      $error("%0d expected words never arrived", due_words.size());
      fails++;
    end
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
